// File: rtl/bzof_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bzof_pkg
// Shared types and constants for the blind-zone obstacle fusion block.
// ----------------------------------------------------------------------------
package bzof_pkg;

  localparam int TABLE_LEN = 24;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [3:0] REG_X_MIN    = 4'd0;
  localparam logic [3:0] REG_X_MAX    = 4'd1;
  localparam logic [3:0] REG_Y_MIN    = 4'd2;
  localparam logic [3:0] REG_Y_MAX    = 4'd3;
  localparam logic [3:0] REG_FRONT    = 4'd4;
  localparam logic [3:0] REG_REAR     = 4'd5;
  localparam logic [3:0] REG_FRONT_TAN = 4'd6;
  localparam logic [3:0] REG_REAR_TAN = 4'd7;

  typedef struct packed {
    logic load_in;
    logic cordic_start;
    logic cordic_sel_cur;
    logic save_rot;
    logic save_cur;
    logic shift_x_step;
    logic shift_y_step;
    logic near_step;
    logic fx_step;
    logic fy_step;
    logic judge;
  } ctrl_t;

  typedef struct packed {
    logic cordic_done;
    logic is_point;
  } stat_t;

  function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
    case (i)
      5'd0:  atan_entry = 34'sh20000000;
      5'd1:  atan_entry = 34'sh12E4051D;
      5'd2:  atan_entry = 34'sh09FB385B;
      5'd3:  atan_entry = 34'sh051111D4;
      5'd4:  atan_entry = 34'sh028B0D43;
      5'd5:  atan_entry = 34'sh0145D7E1;
      5'd6:  atan_entry = 34'sh00A2F61E;
      5'd7:  atan_entry = 34'sh00517C55;
      5'd8:  atan_entry = 34'sh0028BE53;
      5'd9:  atan_entry = 34'sh00145F2E;
      5'd10: atan_entry = 34'sh000A2F98;
      5'd11: atan_entry = 34'sh000517CC;
      5'd12: atan_entry = 34'sh00028BE6;
      5'd13: atan_entry = 34'sh000145F3;
      5'd14: atan_entry = 34'sh0000A2F9;
      5'd15: atan_entry = 34'sh0000517C;
      5'd16: atan_entry = 34'sh000028BE;
      5'd17: atan_entry = 34'sh0000145F;
      5'd18: atan_entry = 34'sh00000A2F;
      5'd19: atan_entry = 34'sh00000517;
      5'd20: atan_entry = 34'sh0000028B;
      5'd21: atan_entry = 34'sh00000145;
      5'd22: atan_entry = 34'sh000000A2;
      5'd23: atan_entry = 34'sh00000051;
      default: atan_entry = 34'sh0;
    endcase
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
    if (v > 36'sd32767) sat16 = 16'sh7FFF;
    else if (v < -36'sd32768) sat16 = 16'sh8000;
    else sat16 = v[15:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/bzof_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bzof_cordic
// Iterative CORDIC, one rotation step per cycle, Q2.14 cosine and sine out.
// ----------------------------------------------------------------------------
module bzof_cordic
  import bzof_pkg::*;
#(
  parameter int STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [15:0]        angle,
  output logic                    done,
  output logic signed [15:0]      cos_out,
  output logic signed [15:0]      sin_out
);

  localparam int N = (STEPS < TABLE_LEN) ? STEPS : TABLE_LEN;

  logic signed [33:0] x, y, z;
  logic [4:0]         i;
  logic               busy, neg;
  logic signed [33:0] zi, xs, ys;
  logic signed [33:0] xr, yr;
  logic signed [17:0] xc, yc;

  always_comb begin
    zi = $signed({{2{angle[15]}}, angle, 16'h0});
    xs = x >>> i;
    ys = y >>> i;
    xr = (x + 34'sd32768) >>> 16;
    yr = (y + 34'sd32768) >>> 16;
    xc = neg ? -xr[17:0] : xr[17:0];
    yc = neg ? -yr[17:0] : yr[17:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        i <= 5'd0;
        x <= CORDIC_GAIN;
        y <= '0;
        if (zi > 34'sh40000000) begin
          z <= zi - 34'sh80000000; neg <= 1'b1;
        end else if (zi < -34'sh40000000) begin
          z <= zi + 34'sh80000000; neg <= 1'b1;
        end else begin
          z <= zi; neg <= 1'b0;
        end
      end else if (busy) begin
        if (i == 5'(N)) begin
          busy <= 1'b0;
          done <= 1'b1;
          cos_out <= (xc > 18'sd16384) ? 16'sd16384 :
                     (xc < -18'sd16384) ? -16'sd16384 : xc[15:0];
          sin_out <= (yc > 18'sd16384) ? 16'sd16384 :
                     (yc < -18'sd16384) ? -16'sd16384 : yc[15:0];
        end else begin
          if (!z[33]) begin
            x <= x - ys; y <= y + xs; z <= z - atan_entry(i);
          end else begin
            x <= x + ys; y <= y - xs; z <= z + atan_entry(i);
          end
          i <= i + 5'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/bzof_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bzof_datapath
// Transform state, shared multiplier and blind-zone decision.
// ----------------------------------------------------------------------------
module bzof_datapath
  import bzof_pkg::*;
#(
  parameter int PERSON_RADIUS = 307,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ctrl_t              ctrl,
  output stat_t                   stat,
  input  wire logic               cfg_we,
  input  wire logic [3:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               func,
  input  wire logic signed [15:0] frame_x,
  input  wire logic signed [15:0] frame_y,
  input  wire logic signed [15:0] frame_heading,
  input  wire logic signed [15:0] current_x,
  input  wire logic signed [15:0] current_y,
  input  wire logic signed [15:0] current_heading,
  input  wire logic signed [15:0] person_x,
  input  wire logic signed [15:0] person_y,
  input  wire logic signed [15:0] point_x,
  input  wire logic signed [15:0] point_y,
  output logic signed [15:0]      fused_x,
  output logic signed [15:0]      fused_y,
  output logic                    keep,
  output logic                    near_person
);

  localparam logic signed [35:0] R2 = 36'(PERSON_RADIUS * PERSON_RADIUS);

  logic signed [15:0] x_min, x_max, y_min, y_max, front, rear;
  logic [15:0]        front_tan, rear_tan;
  logic signed [15:0] rot_cos, rot_sin, shift_x, shift_y, held_px, held_py;
  logic signed [15:0] cc, cs;
  logic               l_func;
  logic signed [15:0] l_fh, l_ch, l_px, l_py, l_pp_x, l_pp_y;
  logic signed [16:0] dx, dy;
  logic signed [15:0] cord_c, cord_s;
  logic               cord_done;
  logic [15:0]        cord_angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_min <= -16'sd5120; x_max <= 16'sd5120;
      y_min <= -16'sd5120; y_max <= 16'sd5120;
      front <= 16'sd512;   rear <= -16'sd512;
      front_tan <= 16'd16384; rear_tan <= 16'd16384;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_X_MIN:     x_min <= cfg_data;
        REG_X_MAX:     x_max <= cfg_data;
        REG_Y_MIN:     y_min <= cfg_data;
        REG_Y_MAX:     y_max <= cfg_data;
        REG_FRONT:     front <= cfg_data;
        REG_REAR:      rear <= cfg_data;
        REG_FRONT_TAN: front_tan <= cfg_data;
        REG_REAR_TAN:  rear_tan <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cord_angle = ctrl.cordic_sel_cur ? l_ch : 16'(l_fh - l_ch);

  bzof_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(ctrl.cordic_start), .angle(cord_angle),
    .done(cord_done), .cos_out(cord_c), .sin_out(cord_s)
  );

  assign stat = '{cordic_done: cord_done, is_point: l_func};

  // one shared multiplier pair per step; each step accumulates two products
  logic signed [16:0] ma0, ma1;
  logic signed [16:0] mb0, mb1;
  logic signed [35:0] p0, p1, acc;
  logic signed [35:0] sum;
  logic signed [35:0] rnd;
  logic signed [16:0] ex, ey;

  always_comb begin
    ex = 17'(l_px) - 17'(held_px);
    ey = 17'(l_py) - 17'(held_py);
    ma0 = '0; mb0 = '0; ma1 = '0; mb1 = '0; acc = '0;
    if (ctrl.shift_x_step) begin
      ma0 = dx; mb0 = 17'(cc); ma1 = dy; mb1 = 17'(cs);
    end else if (ctrl.shift_y_step) begin
      ma0 = dy; mb0 = 17'(cc); ma1 = -dx; mb1 = 17'(cs);
    end else if (ctrl.near_step) begin
      ma0 = ex; mb0 = ex; ma1 = ey; mb1 = ey;
    end else if (ctrl.fx_step) begin
      ma0 = 17'(l_px); mb0 = 17'(rot_cos); ma1 = -17'(l_py); mb1 = 17'(rot_sin);
      acc = 36'(shift_x) <<< 14;
    end else if (ctrl.fy_step) begin
      ma0 = 17'(l_px); mb0 = 17'(rot_sin); ma1 = 17'(l_py); mb1 = 17'(rot_cos);
      acc = 36'(shift_y) <<< 14;
    end
    p0 = 36'(ma0 * mb0);
    p1 = 36'(ma1 * mb1);
    sum = p0 + p1 + acc;
    rnd = (sum + 36'sd8192) >>> 14;
  end

  logic near_r;
  logic signed [33:0] cone_a, cone_y;
  logic signed [15:0] tan_sel;
  logic in_win, strip, cone_hit;

  always_comb begin
    in_win = !(fused_y > y_max || fused_y < y_min || fused_x > x_max || fused_x < x_min);
    strip = fused_y < 16'sd256 && fused_y > -16'sd256 && fused_x < front && fused_x > rear;
    tan_sel = (fused_x > front) ? front_tan : rear_tan;
    cone_a = 34'(fused_x) * $signed({18'h0, tan_sel});
    if (cone_a < 0) cone_a = -cone_a;
    cone_y = 34'(fused_y) <<< 14;
    cone_hit = cone_y <= cone_a && cone_y >= -cone_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_cos <= '0; rot_sin <= '0; shift_x <= '0; shift_y <= '0;
      held_px <= '0; held_py <= '0;
    end else begin
      if (ctrl.load_in) begin
        l_func <= func; l_fh <= frame_heading; l_ch <= current_heading;
        l_px <= point_x; l_py <= point_y; l_pp_x <= person_x; l_pp_y <= person_y;
        dx <= 17'(frame_x) - 17'(current_x);
        dy <= 17'(frame_y) - 17'(current_y);
      end
      if (ctrl.save_rot) begin
        rot_cos <= cord_c; rot_sin <= cord_s;
      end
      if (ctrl.save_cur) begin
        cc <= cord_c; cs <= cord_s;
      end
      if (ctrl.shift_x_step) shift_x <= sat16(rnd);
      if (ctrl.shift_y_step) begin
        shift_y <= sat16(rnd);
        held_px <= l_pp_x; held_py <= l_pp_y;
      end
      if (ctrl.near_step) near_r <= sum <= R2;
      if (ctrl.fx_step) fused_x <= near_r ? 16'sd0 : sat16(rnd);
      if (ctrl.fy_step) fused_y <= near_r ? 16'sd0 : sat16(rnd);
      if (ctrl.judge) begin
        near_person <= near_r;
        if (near_r || !in_win || strip) keep <= 1'b0;
        else if (fused_x > front || fused_x < rear) keep <= !cone_hit;
        else keep <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/bzof_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bzof_ctrl
// Sequencer for pose and point items and the output handshake.
// ----------------------------------------------------------------------------
module bzof_ctrl
  import bzof_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire stat_t stat,
  output ctrl_t     ctrl
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_ROT  = 4'd2;
  localparam logic [3:0] S_CUR  = 4'd3;
  localparam logic [3:0] S_SX   = 4'd4;
  localparam logic [3:0] S_SY   = 4'd5;
  localparam logic [3:0] S_NEAR = 4'd6;
  localparam logic [3:0] S_FX   = 4'd7;
  localparam logic [3:0] S_FY   = 4'd8;
  localparam logic [3:0] S_JDG  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [3:0] state, state_next;
  logic       accept;

  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign out_valid = (state == S_OUT);

  always_comb begin
    ctrl = '0;
    state_next = state;
    case (state)
      S_IDLE: if (accept) begin ctrl.load_in = 1'b1; state_next = S_DEC; end
      S_DEC: begin
        if (stat.is_point) state_next = S_NEAR;
        else begin ctrl.cordic_start = 1'b1; state_next = S_ROT; end
      end
      S_ROT: if (stat.cordic_done) begin
        ctrl.save_rot = 1'b1; ctrl.cordic_start = 1'b1;
        ctrl.cordic_sel_cur = 1'b1; state_next = S_CUR;
      end
      S_CUR: if (stat.cordic_done) begin ctrl.save_cur = 1'b1; state_next = S_SX; end
      S_SX: begin ctrl.shift_x_step = 1'b1; state_next = S_SY; end
      S_SY: begin ctrl.shift_y_step = 1'b1; state_next = S_IDLE; end
      S_NEAR: begin ctrl.near_step = 1'b1; state_next = S_FX; end
      S_FX: begin ctrl.fx_step = 1'b1; state_next = S_FY; end
      S_FY: begin ctrl.fy_step = 1'b1; state_next = S_JDG; end
      S_JDG: begin ctrl.judge = 1'b1; state_next = S_OUT; end
      S_OUT: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  a_one_owner: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && !in_stall)) else $error("output shown while idle");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_DEC) else $error("accept not sequenced");

endmodule
`default_nettype wire

// File: rtl/blind_zone_obstacle_fusion_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blind_zone_obstacle_fusion_core
// Moves past-keyframe obstacles into the current frame and flags blind-zone
// points.
//
// Input channel: valid/stall. A pose item (func 0) loads the rotation, the
// translation and the person position and gives no result. A point item
// (func 1) gives one result on the output channel.
// A point item passes the shared multiplier pair, used in turn for the
// person distance, x and y, then the blind-zone decision before its result
// is valid; the next item is accepted once the result has been taken. A
// pose item keeps the input stalled while the one CORDIC unit is run twice
// and the translation is rotated. One item is in flight at a time; the
// input is stalled meanwhile. Stall on the output holds the result and the
// input stays stalled. Reset clears the transform to zero (points then map
// to the origin) and loads the register defaults. Registers are written at
// any clock edge with cfg_we high; the user is to write them only while the
// block is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module blind_zone_obstacle_fusion_core
  import bzof_pkg::*;
#(
  parameter int PERSON_RADIUS = 307,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [3:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               func,
  input  wire logic signed [15:0] frame_x,
  input  wire logic signed [15:0] frame_y,
  input  wire logic signed [15:0] frame_heading,
  input  wire logic signed [15:0] current_x,
  input  wire logic signed [15:0] current_y,
  input  wire logic signed [15:0] current_heading,
  input  wire logic signed [15:0] person_x,
  input  wire logic signed [15:0] person_y,
  input  wire logic signed [15:0] point_x,
  input  wire logic signed [15:0] point_y,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      fused_x,
  output logic signed [15:0]      fused_y,
  output logic                    keep,
  output logic                    near_person
);

  ctrl_t ctrl;
  stat_t stat;

  bzof_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .ctrl(ctrl)
  );

  bzof_datapath #(.PERSON_RADIUS(PERSON_RADIUS), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk(clk), .rst(rst), .ctrl(ctrl), .stat(stat),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .func(func), .frame_x(frame_x), .frame_y(frame_y),
    .frame_heading(frame_heading), .current_x(current_x), .current_y(current_y),
    .current_heading(current_heading), .person_x(person_x), .person_y(person_y),
    .point_x(point_x), .point_y(point_y), .fused_x(fused_x), .fused_y(fused_y),
    .keep(keep), .near_person(near_person)
  );

endmodule
`default_nettype wire
